>>> hw/rtl/ascii_time_of_day_clock_macros.svh
// Assertion macros used by the time-of-day clock RTL
`ifndef ASCII_TIME_OF_DAY_CLOCK_MACROS_SVH
`define ASCII_TIME_OF_DAY_CLOCK_MACROS_SVH

// Same-cycle implication, checked on every rising clk edge out of reset
`define ATODC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising clk edge out of reset
`define ATODC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/atodc_pkg.sv
// Shared types, constants and digit helpers for the time-of-day clock
package atodc_pkg;

    // Opcodes of an input beat
    localparam logic [1:0] OP_TICK   = 2'd0;
    localparam logic [1:0] OP_CHAR   = 2'd1;
    localparam logic [1:0] OP_COMMIT = 2'd2;
    localparam logic [1:0] OP_READ   = 2'd3;

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_NOTIFY = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LINK   = 1'd1;

    // Characters
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_COLON = 8'h3A;

    // Time limits
    localparam logic [4:0] HOUR_MAX = 5'd23;
    localparam logic [5:0] MIN_MAX  = 6'd59;
    localparam logic [5:0] SEC_MAX  = 6'd59;

    // Parser slot that means all three fields are closed
    localparam logic [1:0] SLOT_FULL = 2'd3;
    localparam int NUM_FIELDS = 3;

    // One output run is HH:MM:SS
    localparam int RUN_LEN = 8;
    localparam int IDX_W   = $clog2(RUN_LEN);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(RUN_LEN - 1);

    // Snapshot of the time as decimal digits, plus the run kind
    typedef struct packed {
        logic [3:0] h_tens;
        logic [3:0] h_ones;
        logic [3:0] m_tens;
        logic [3:0] m_ones;
        logic [3:0] s_tens;
        logic [3:0] s_ones;
        logic       is_read;
    } run_t;

    // Request from the clock core to the serializer
    typedef struct packed {
        logic push;
        run_t run;
    } ser_req_t;

    // Split a value below 60 into tens and ones by a short compare chain
    function automatic logic [7:0] to_digits(input logic [5:0] value);
        logic [3:0] tens;
        logic [5:0] rest;
        tens = 4'd0;
        rest = value;
        for (int k = 0; k < 5; k++) begin
            if (rest >= 6'd10) begin
                rest = rest - 6'd10;
                tens = tens + 4'd1;
            end
        end
        return {tens, rest[3:0]};
    endfunction

endpackage

>>> hw/rtl/ascii_time_of_day_clock.sv
// Time-of-day clock: an input beat is taken on every cycle while the one-run holding slot is
// free; a tick with notify_enable and link_up set, or a read, yields an eight-beat HH:MM:SS run
// on the output, one character per cycle while out_ready is high, from the output serializer.
// A second run waits in the holding slot, and in_ready is low while that slot is full; ticks,
// set characters and commits that yield nothing never fill the slot.
module ascii_time_of_day_clock (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [1:0]                       opcode,
    input  logic [7:0]                       in_char,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [7:0]                       out_char,
    output logic                             out_last,
    output logic                             out_is_read,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [atodc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic                             cfg_data
);

    logic       notify_en_reg;
    logic       link_up_reg;
    logic [4:0] hour_reg,  hour_next;
    logic [5:0] min_reg,   min_next;
    logic [5:0] sec_reg,   sec_next;
    logic [7:0] field_reg  [0:atodc_pkg::NUM_FIELDS-1];
    logic [7:0] field_next [0:atodc_pkg::NUM_FIELDS-1];
    logic [1:0] slot_reg,  slot_next;

    logic                in_fire;
    logic                ser_full;
    logic                is_digit;
    logic [3:0]          digit;
    atodc_pkg::ser_req_t ser_req;
    logic [7:0]          h_dig, m_dig, s_dig;

    assign cfg_ready = 1'b1;
    assign in_ready  = !ser_full;
    assign in_fire   = in_valid && in_ready;
    assign is_digit  = (in_char >= atodc_pkg::CHAR_ZERO) && (in_char <= atodc_pkg::CHAR_NINE);
    assign digit     = 4'(in_char - atodc_pkg::CHAR_ZERO);

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            notify_en_reg <= 1'b0;
            link_up_reg   <= 1'b0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                atodc_pkg::REG_NOTIFY: notify_en_reg <= cfg_data;
                atodc_pkg::REG_LINK:   link_up_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // Clock and parser next state
    always_comb
    begin
        hour_next = hour_reg;
        min_next  = min_reg;
        sec_next  = sec_reg;
        slot_next = slot_reg;
        for (int i = 0; i < atodc_pkg::NUM_FIELDS; i++)
        begin
            field_next[i] = field_reg[i];
        end
        if (in_fire)
        begin
            case (opcode)
                atodc_pkg::OP_TICK:
                begin
                    if (sec_reg >= atodc_pkg::SEC_MAX)
                    begin
                        sec_next = '0;
                        if (min_reg >= atodc_pkg::MIN_MAX)
                        begin
                            min_next  = '0;
                            hour_next = (hour_reg >= atodc_pkg::HOUR_MAX) ? '0
                                                                          : hour_reg + 1'b1;
                        end
                        else
                        begin
                            min_next = min_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        sec_next = sec_reg + 1'b1;
                    end
                end
                atodc_pkg::OP_CHAR:
                begin
                    if (slot_reg != atodc_pkg::SLOT_FULL)
                    begin
                        if (is_digit)
                        begin
                            // field = field * 10 + digit, kept to eight bits
                            for (int i = 0; i < atodc_pkg::NUM_FIELDS; i++)
                            begin
                                if (slot_reg == 2'(i))
                                begin
                                    field_next[i] = (field_reg[i] << 3) + (field_reg[i] << 1)
                                                    + {4'd0, digit};
                                end
                            end
                        end
                        else if (in_char == atodc_pkg::CHAR_COLON)
                        begin
                            slot_next = slot_reg + 1'b1;
                        end
                    end
                end
                atodc_pkg::OP_COMMIT:
                begin
                    hour_next = (field_reg[0] > {3'd0, atodc_pkg::HOUR_MAX})
                              ? atodc_pkg::HOUR_MAX : field_reg[0][4:0];
                    min_next  = (field_reg[1] > {2'd0, atodc_pkg::MIN_MAX})
                              ? atodc_pkg::MIN_MAX : field_reg[1][5:0];
                    sec_next  = (field_reg[2] > {2'd0, atodc_pkg::SEC_MAX})
                              ? atodc_pkg::SEC_MAX : field_reg[2][5:0];
                    slot_next = '0;
                    for (int i = 0; i < atodc_pkg::NUM_FIELDS; i++)
                    begin
                        field_next[i] = '0;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hour_reg <= '0;
            min_reg  <= '0;
            sec_reg  <= '0;
            slot_reg <= '0;
            for (int i = 0; i < atodc_pkg::NUM_FIELDS; i++)
            begin
                field_reg[i] <= '0;
            end
        end
        else
        begin
            hour_reg <= hour_next;
            min_reg  <= min_next;
            sec_reg  <= sec_next;
            slot_reg <= slot_next;
            for (int i = 0; i < atodc_pkg::NUM_FIELDS; i++)
            begin
                field_reg[i] <= field_next[i];
            end
        end
    end

    // Snapshot of the time after this beat, as digits, for a run
    assign h_dig = atodc_pkg::to_digits({1'b0, hour_next});
    assign m_dig = atodc_pkg::to_digits(min_next);
    assign s_dig = atodc_pkg::to_digits(sec_next);

    always_comb
    begin
        ser_req.push = in_fire &&
                       (((opcode == atodc_pkg::OP_TICK) && notify_en_reg && link_up_reg) ||
                        (opcode == atodc_pkg::OP_READ));
        ser_req.run.h_tens  = h_dig[7:4];
        ser_req.run.h_ones  = h_dig[3:0];
        ser_req.run.m_tens  = m_dig[7:4];
        ser_req.run.m_ones  = m_dig[3:0];
        ser_req.run.s_tens  = s_dig[7:4];
        ser_req.run.s_ones  = s_dig[3:0];
        ser_req.run.is_read = (opcode == atodc_pkg::OP_READ);
    end

    atodc_serializer u_serializer (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (ser_req),
        .full        (ser_full),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_char    (out_char),
        .out_last    (out_last),
        .out_is_read (out_is_read)
    );

endmodule

>>> hw/rtl/atodc_serializer.sv
// Holding slot and eight-beat output serializer for HH:MM:SS runs
`include "ascii_time_of_day_clock_macros.svh"

module atodc_serializer (
    input  logic               clk,
    input  logic               rst_n,
    input  atodc_pkg::ser_req_t req,
    output logic               full,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [7:0]         out_char,
    output logic               out_last,
    output logic               out_is_read
);

    logic                       pend_valid_reg;
    atodc_pkg::run_t            pend_run_reg;
    logic                       act_valid_reg;
    atodc_pkg::run_t            act_run_reg;
    logic [atodc_pkg::IDX_W-1:0] idx_reg;

    logic out_fire;
    logic run_done;
    logic load_act;

    assign full      = pend_valid_reg;
    assign out_valid = act_valid_reg;
    assign out_fire  = act_valid_reg && out_ready;
    assign run_done  = out_fire && (idx_reg == atodc_pkg::LAST_IDX);
    // Active stage takes the held run when it is empty or finishing
    assign load_act  = pend_valid_reg && (!act_valid_reg || run_done);

    // Holding slot
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
        end
        else if (req.push)
        begin
            pend_valid_reg <= 1'b1;
        end
        else if (load_act)
        begin
            pend_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.push)
        begin
            pend_run_reg <= req.run;
        end
    end

    // Active run and character index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else if (load_act)
        begin
            act_valid_reg <= 1'b1;
            idx_reg       <= '0;
        end
        else if (run_done)
        begin
            act_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else if (out_fire)
        begin
            idx_reg <= idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_act)
        begin
            act_run_reg <= pend_run_reg;
        end
    end

    // Character select for the current beat
    always_comb
    begin
        case (idx_reg)
            3'd0:    out_char = atodc_pkg::CHAR_ZERO + {4'd0, act_run_reg.h_tens};
            3'd1:    out_char = atodc_pkg::CHAR_ZERO + {4'd0, act_run_reg.h_ones};
            3'd3:    out_char = atodc_pkg::CHAR_ZERO + {4'd0, act_run_reg.m_tens};
            3'd4:    out_char = atodc_pkg::CHAR_ZERO + {4'd0, act_run_reg.m_ones};
            3'd6:    out_char = atodc_pkg::CHAR_ZERO + {4'd0, act_run_reg.s_tens};
            3'd7:    out_char = atodc_pkg::CHAR_ZERO + {4'd0, act_run_reg.s_ones};
            default: out_char = atodc_pkg::CHAR_COLON;
        endcase
    end

    assign out_last    = (idx_reg == atodc_pkg::LAST_IDX);
    assign out_is_read = act_run_reg.is_read;

    // Checks
    `ATODC_ASSERT_NOW(a_push_into_empty, req.push, !pend_valid_reg, "run pushed into full slot")
    `ATODC_ASSERT_NEXT(a_run_ends, run_done && !pend_valid_reg, !act_valid_reg, "run did not end")
    `ATODC_ASSERT_NEXT(a_idx_step, out_fire && !run_done, act_valid_reg && (idx_reg == $past(idx_reg) + 1'b1), "index did not advance")
    `ATODC_ASSERT_NOW(a_start_at_zero, $rose(act_valid_reg), idx_reg == '0, "run started mid-way")

endmodule

>>> tb/tb_ascii_time_of_day_clock.sv
// Self-checking testbench for the ASCII time-of-day clock: directed table plus random traffic
`timescale 1ns / 100ps

module tb_ascii_time_of_day_clock;
    import atodc_pkg::*;

    localparam int SETTLE_CYCLES   = 12;
    localparam int MAX_GAP         = 20;
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int NUM_PHASES      = 6;
    localparam int ITEMS_PER_PHASE = 60;
    localparam int DIR_ROWS        = 30;

    // One output character beat
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        logic       is_read;
    } char_beat_t;

    // One input beat, optionally carrying the literal text it must produce
    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  ch;
        logic        typed;
        logic [63:0] text;
    } stim_t;

    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

    typedef struct packed {
        row_kind_e                kind;
        logic [1:0]               op;
        logic [7:0]               ch;
        logic [CFG_IDX_W-1:0]     reg_idx;
        logic                     reg_val;
        logic                     typed;
        logic [63:0]              text;
    } dir_row_t;

    // DUT signals
    logic                 clk;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_ready;
    logic [1:0]           opcode    = OP_TICK;
    logic [7:0]           in_char   = 8'h00;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [7:0]           out_char;
    logic                 out_last;
    logic                 out_is_read;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = REG_NOTIFY;
    logic                 cfg_data  = 1'b0;

    // Side info travelling with the input beat in flight
    logic        cur_typed = 1'b0;
    logic [63:0] cur_text  = '0;

    // Clock model state
    logic [4:0] clk_hour   = '0;
    logic [5:0] clk_min    = '0;
    logic [5:0] clk_sec    = '0;
    logic [7:0] set_field [NUM_FIELDS] = '{default: 8'h00};
    logic [1:0] set_slot   = '0;
    logic       notify_en  = 1'b0;
    logic       link_en    = 1'b0;

    char_beat_t expected_chars[$];
    stim_t      stim_q[$];

    int error_count   = 0;
    int items_taken   = 0;
    int chars_checked = 0;
    int reg_writes    = 0;
    int idle_cycles   = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    // Directed stimulus; literal text only where it is obvious
    dir_row_t dir_table [DIR_ROWS] = '{
        '{ROW_ITEM, OP_READ,   8'h00,      REG_NOTIFY, 1'b0, 1'b1, "00:00:00"},
        '{ROW_ITEM, OP_TICK,   8'hFF,      REG_NOTIFY, 1'b0, 1'b0, 64'd0},
        '{ROW_ITEM, OP_CHAR,   "2",        REG_NOTIFY, 1'b0, 1'b0, 64'd0},
        '{ROW_ITEM, OP_CHAR,   "3",        REG_NOTIFY, 1'b0, 1'b0, 64'd0},
        '{ROW_ITEM, OP_CHAR,   CHAR_COLON, REG_NOTIFY, 1'b0, 1'b0, 64'd0},
        '{ROW_ITEM, OP_CHAR,   "5",        REG_NOTIFY, 1'b0, 1'b0, 64'd0},
        '{ROW_ITEM, OP_CHAR,   "9",        REG_NOTIFY, 1'b0, 1'b0, 64'd0},
        '{ROW_ITEM, OP_CHAR,   CHAR_COLON, REG_NOTIFY, 1'b0, 1'b0, 64'd0},
        '{ROW_ITEM, OP_CHAR,   "5",        REG_NOTIFY, 1'b0, 1'b0, 64'd0},
        '{ROW_ITEM, OP_CHAR,   "9",        REG_NOTIFY, 1'b0, 1'b0, 64'd0},
        '{ROW_ITEM, OP_COMMIT, 8'h00,      REG_NOTIFY, 1'b0, 1'b0, 64'd0},
        '{ROW_ITEM, OP_READ,   8'hFF,      REG_NOTIFY, 1'b0, 1'b1, "23:59:59"},
        '{ROW_CFG,  OP_TICK,   8'h00,      REG_NOTIFY, 1'b1, 1'b0, 64'd0},
        '{ROW_CFG,  OP_TICK,   8'h00,      REG_LINK,   1'b1, 1'b0, 64'd0},
        // midnight wrap, sent as a notification
        '{ROW_ITEM, OP_TICK,   8'h00,      REG_NOTIFY, 1'b0, 1'b1, "00:00:00"},
        // hours field overflows modulo 256 and is clamped on commit
        '{ROW_ITEM, OP_CHAR,   "9",        REG_NOTIFY, 1'b0, 1'b0, 64'd0},
        '{ROW_ITEM, OP_CHAR,   "9",        REG_NOTIFY, 1'b0, 1'b0, 64'd0},
        '{ROW_ITEM, OP_CHAR,   "9",        REG_NOTIFY, 1'b0, 1'b0, 64'd0},
        '{ROW_ITEM, OP_CHAR,   CHAR_COLON, REG_NOTIFY, 1'b0, 1'b0, 64'd0},
        '{ROW_ITEM, OP_CHAR,   8'hFF,      REG_NOTIFY, 1'b0, 1'b0, 64'd0},
        '{ROW_ITEM, OP_CHAR,   CHAR_COLON, REG_NOTIFY, 1'b0, 1'b0, 64'd0},
        '{ROW_ITEM, OP_CHAR,   CHAR_COLON, REG_NOTIFY, 1'b0, 1'b0, 64'd0},
        // parser full: digits and other bytes are dropped
        '{ROW_ITEM, OP_CHAR,   "7",        REG_NOTIFY, 1'b0, 1'b0, 64'd0},
        '{ROW_ITEM, OP_CHAR,   8'h00,      REG_NOTIFY, 1'b0, 1'b0, 64'd0},
        '{ROW_ITEM, OP_COMMIT, 8'hFF,      REG_NOTIFY, 1'b0, 1'b0, 64'd0},
        '{ROW_ITEM, OP_READ,   8'h00,      REG_NOTIFY, 1'b0, 1'b0, 64'd0},
        '{ROW_ITEM, OP_TICK,   8'h00,      REG_NOTIFY, 1'b0, 1'b0, 64'd0},
        '{ROW_CFG,  OP_TICK,   8'h00,      REG_NOTIFY, 1'b0, 1'b0, 64'd0},
        '{ROW_ITEM, OP_TICK,   8'hFF,      REG_NOTIFY, 1'b0, 1'b0, 64'd0},
        '{ROW_ITEM, OP_READ,   8'hFF,      REG_NOTIFY, 1'b0, 1'b0, 64'd0}
    };

    ascii_time_of_day_clock u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .opcode     (opcode),
        .in_char    (in_char),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_char   (out_char),
        .out_last   (out_last),
        .out_is_read(out_is_read),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    // 50 MHz clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // ---------------------------------------------------------------
    // Clock model
    // ---------------------------------------------------------------
    function automatic logic [7:0] digit_char(input int d);
        return 8'(int'(CHAR_ZERO) + d);
    endfunction

    function automatic logic [63:0] time_text();
        return {digit_char(int'(clk_hour) / 10), digit_char(int'(clk_hour) % 10), CHAR_COLON,
                digit_char(int'(clk_min) / 10),  digit_char(int'(clk_min) % 10),  CHAR_COLON,
                digit_char(int'(clk_sec) / 10),  digit_char(int'(clk_sec) % 10)};
    endfunction

    task automatic advance_time();
        if (clk_sec >= SEC_MAX)
        begin
            clk_sec = '0;
            if (clk_min >= MIN_MAX)
            begin
                clk_min  = '0;
                clk_hour = (clk_hour >= HOUR_MAX) ? 5'd0 : clk_hour + 5'd1;
            end
            else
                clk_min = clk_min + 6'd1;
        end
        else
            clk_sec = clk_sec + 6'd1;
    endtask

    // Update the model for one accepted beat and queue the characters it yields
    task automatic apply_beat(input logic [1:0] op, input logic [7:0] ch,
                              input logic typed, input logic [63:0] text);
        logic        emits;
        logic [63:0] txt;
        char_beat_t  cb;
        emits = 1'b0;
        case (op)
            OP_TICK:
            begin
                advance_time();
                emits = notify_en && link_en;
            end
            OP_CHAR:
            begin
                if (set_slot != SLOT_FULL)
                begin
                    if (ch >= CHAR_ZERO && ch <= CHAR_NINE)
                        set_field[set_slot] = 8'(set_field[set_slot] * 10 + (ch - CHAR_ZERO));
                    else if (ch == CHAR_COLON)
                        set_slot = set_slot + 2'd1;
                end
            end
            OP_COMMIT:
            begin
                clk_hour  = (set_field[0] > 8'(HOUR_MAX)) ? HOUR_MAX : set_field[0][4:0];
                clk_min   = (set_field[1] > 8'(MIN_MAX))  ? MIN_MAX  : set_field[1][5:0];
                clk_sec   = (set_field[2] > 8'(SEC_MAX))  ? SEC_MAX  : set_field[2][5:0];
                set_field = '{default: 8'h00};
                set_slot  = '0;
            end
            default:
                emits = 1'b1;
        endcase
        if (emits)
        begin
            txt = typed ? text : time_text();
            for (int k = 0; k < RUN_LEN; k++)
            begin
                cb.ch      = txt[63 - 8 * k -: 8];
                cb.last    = (k == RUN_LEN - 1);
                cb.is_read = (op == OP_READ);
                expected_chars.push_back(cb);
            end
        end
        items_taken++;
    endtask

    task automatic report_error(input string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        error_count++;
    endtask

    // ---------------------------------------------------------------
    // Monitor, scoreboard and watchdog
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            // output beat against the oldest expected character
            if (out_valid && out_ready)
            begin
                if (expected_chars.size() == 0)
                    report_error($sformatf("unexpected char 0x%02h", out_char));
                else
                begin
                    char_beat_t want;
                    want = expected_chars.pop_front();
                    if (out_char !== want.ch)
                        report_error($sformatf("out_char 0x%02h, want 0x%02h", out_char, want.ch));
                    if (out_last !== want.last)
                        report_error($sformatf("out_last %b, want %b", out_last, want.last));
                    if (out_is_read !== want.is_read)
                        report_error($sformatf("out_is_read %b, want %b",
                                               out_is_read, want.is_read));
                    chars_checked++;
                end
            end
            // accepted input beat
            if (in_valid && in_ready)
                apply_beat(opcode, in_char, cur_typed, cur_text);
            // register write
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_NOTIFY)
                    notify_en = cfg_data;
                else
                    link_en = cfg_data;
                reg_writes++;
            end
            // watchdog on cycles with no beat on any channel
            if ((out_valid && out_ready) || (in_valid && in_ready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Timeout: no beat for %0d cycles", WATCHDOG_LIMIT);
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // Receiver back-pressure
    always @(posedge clk)
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);

    // ---------------------------------------------------------------
    // Drivers
    // ---------------------------------------------------------------
    task automatic set_idling(input int mode);
        case (mode)
            0:
            begin
                send_idle_pct = 13;
                recv_idle_pct = 71;
            end
            1:
            begin
                send_idle_pct = 71;
                recv_idle_pct = 13;
            end
            default:
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
        endcase
    endtask

    // Send one input beat; valid stays high afterwards for back-to-back beats
    task automatic send_beat(input stim_t it);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(0, 99) < send_idle_pct)
        begin
            if (gap == 0)
                in_valid <= 1'b0;
            @(posedge clk);
            gap++;
        end
        in_valid  <= 1'b1;
        opcode    <= it.op;
        in_char   <= it.ch;
        cur_typed <= it.typed;
        cur_text  <= it.text;
        @(posedge clk);
        while (!(in_valid && in_ready))
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!(cfg_valid && cfg_ready))
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Wait for the monitor to log the last accepted beat and for all expected
    // characters, then let any silent beat retire
    task automatic drain_and_settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_chars.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // ---------------------------------------------------------------
    // Random stimulus builders
    // ---------------------------------------------------------------
    task automatic queue_beat(input logic [1:0] op, input logic [7:0] ch);
        stim_t it;
        it.op    = op;
        it.ch    = ch;
        it.typed = 1'b0;
        it.text  = '0;
        stim_q.push_back(it);
    endtask

    task automatic queue_number(input int v);
        if (v >= 100)
            queue_beat(OP_CHAR, digit_char(v / 100));
        if (v >= 10)
            queue_beat(OP_CHAR, digit_char((v / 10) % 10));
        queue_beat(OP_CHAR, digit_char(v % 10));
    endtask

    // Set text, usually a commit, then a few ticks and maybe a read
    task automatic queue_set_sequence(input bit near_midnight);
        int v;
        int lim;
        for (int f = 0; f < NUM_FIELDS; f++)
        begin
            lim = (f == 0) ? int'(HOUR_MAX) : int'(MIN_MAX);
            if (near_midnight)
                v = (f == 2) ? $urandom_range(55, 59) : lim;
            else
                case ($urandom_range(0, 3))
                    0:       v = lim - 1 + $urandom_range(0, 2);
                    1:       v = $urandom_range(0, 999);
                    default: v = $urandom_range(0, lim);
                endcase
            queue_number(v);
            if ($urandom_range(0, 7) == 0)
                queue_beat(OP_CHAR, 8'($urandom_range(0, 255)));
            if (f < 2 || $urandom_range(0, 3) == 0)
                queue_beat(OP_CHAR, CHAR_COLON);
        end
        // now and then the commit goes missing and the parser carries over
        if ($urandom_range(0, 9) != 0)
            queue_beat(OP_COMMIT, 8'($urandom_range(0, 255)));
        repeat ($urandom_range(1, near_midnight ? 6 : 3))
            queue_beat(OP_TICK, 8'($urandom_range(0, 255)));
        if ($urandom_range(0, 1) == 0)
            queue_beat(OP_READ, 8'($urandom_range(0, 255)));
    endtask

    task automatic build_random_items(input int count);
        int r;
        while (stim_q.size() < count)
        begin
            r = $urandom_range(0, 99);
            if (r < 15)
                queue_set_sequence(1'b1);
            else if (r < 60)
                queue_set_sequence(1'b0);
            else if (r < 80)
            begin
                repeat ($urandom_range(1, 4))
                    queue_beat(OP_TICK, 8'($urandom_range(0, 255)));
                queue_beat(OP_READ, 8'($urandom_range(0, 255)));
            end
            else
                repeat ($urandom_range(1, 4))
                    queue_beat(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
        end
    endtask

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial
    begin
        bit    notify_plan [NUM_PHASES];
        bit    link_plan   [NUM_PHASES];
        stim_t it;

        notify_plan = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};
        link_plan   = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};

        set_idling(0);
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // directed table
        for (int i = 0; i < DIR_ROWS; i++)
        begin
            if (dir_table[i].kind == ROW_CFG)
            begin
                drain_and_settle();
                write_reg(dir_table[i].reg_idx, dir_table[i].reg_val);
            end
            else
            begin
                it.op    = dir_table[i].op;
                it.ch    = dir_table[i].ch;
                it.typed = dir_table[i].typed;
                it.text  = dir_table[i].text;
                send_beat(it);
            end
        end

        // random phases, each writing its register setting; each pair of phases shares an idling mode
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            drain_and_settle();
            set_idling(p / 2);
            write_reg(REG_NOTIFY, notify_plan[p]);
            drain_and_settle();
            write_reg(REG_LINK, link_plan[p]);
            build_random_items(ITEMS_PER_PHASE);
            while (stim_q.size() != 0)
            begin
                it = stim_q.pop_front();
                send_beat(it);
            end
        end

        drain_and_settle();
        if (expected_chars.size() != 0)
            report_error($sformatf("%0d expected chars never arrived", expected_chars.size()));

        $display("Run covered %0d input beats (ticks, set text, commits, reads) and %0d",
                 items_taken, reg_writes);
        $display("register writes; %0d output characters were checked", chars_checked);
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/atodc_pkg.sv
hw/rtl/atodc_serializer.sv
hw/rtl/ascii_time_of_day_clock.sv
tb/tb_ascii_time_of_day_clock.sv
